// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the core modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define GTR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, held off during reset
`define GTR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== rtl/core/gtr_pkg.sv =====
package gtr_pkg;

    localparam int ADDR_W    = 48;
    localparam int LP_W      = 14;
    localparam int COL_W     = 11;
    localparam int ROW_W     = 12;
    localparam int FONT_AW   = 12;
    localparam int BYTE_W    = 8;
    localparam int RCNT_W    = 4;
    localparam int Y_W       = ROW_W + RCNT_W;
    localparam int PROD_W    = Y_W + LP_W;

    localparam logic [RCNT_W-1:0] LAST_GLYPH_ROW = 4'd15;
    localparam logic [BYTE_W-1:0] NEWLINE_CODE   = 8'd10;

    // item kinds after classification
    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NEWLINE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DRAW    = 2'd2;

    // command field codes
    localparam logic CMD_LOAD = 1'b0;

    // register select bit of paddr (8-byte register slots)
    localparam int  PADDR_W         = 4;
    localparam logic REG_FB_BASE     = 1'b0;
    localparam logic REG_LINE_PIXELS = 1'b1;
    localparam logic [LP_W-1:0] LINE_PIXELS_RESET = 14'd1024;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FONT_AW-1:0] font_addr;
        logic [BYTE_W-1:0]  font_byte;
    } q_item_t;

endpackage

// ===== rtl/core/gtr_front.sv =====
`include "assert_macros.svh"

module gtr_front #(
    parameter int GLYPH_COUNT = 256,
    parameter int GLYPH_BYTES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          cmd,
    input  logic [gtr_pkg::BYTE_W-1:0]    char_code,
    input  logic [gtr_pkg::FONT_AW-1:0]   font_index,
    input  logic [gtr_pkg::BYTE_W-1:0]    font_byte,
    output logic                          busy,
    output logic                          q_valid,
    output gtr_pkg::q_item_t              q_item,
    input  logic                          q_pop
);
    import gtr_pkg::*;

    localparam int FPROD_W = BYTE_W + 6;

    q_item_t             queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    logic                push;
    logic [BYTE_W-1:0]   glyph;
    logic [FPROD_W-1:0]  font_prod;
    q_item_t             new_item;

    assign busy    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push    = start && !busy;
    assign q_valid = (count_reg != '0);
    assign q_item  = queue_reg[rd_ptr_reg];

    // classify and turn a draw into its glyph's first font byte
    always_comb
    begin
        if ({1'b0, char_code} >= 9'(GLYPH_COUNT))
        begin
            glyph = char_code - BYTE_W'(GLYPH_COUNT);
        end
        else
        begin
            glyph = char_code;
        end
        font_prod = FPROD_W'(glyph) * FPROD_W'(GLYPH_BYTES);

        new_item.font_byte = font_byte;
        priority if (cmd == CMD_LOAD)
        begin
            new_item.kind      = KIND_LOAD;
            new_item.font_addr = font_index;
        end
        else if (char_code == NEWLINE_CODE)
        begin
            new_item.kind      = KIND_NEWLINE;
            new_item.font_addr = font_index;
        end
        else
        begin
            new_item.kind      = KIND_DRAW;
            new_item.font_addr = font_prod[FONT_AW-1:0];
        end
    end

    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        unique case ({push, q_pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_item;
        end
    end

    `GTR_ASSERT_IMP(a_pop_needs_entry, clk, rst_n, q_pop, count_reg != '0)
    `GTR_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH))
    `GTR_ASSERT_NXT(a_push_counts, clk, rst_n, push && !q_pop, count_reg == $past(count_reg) + QCNT_W'(1))

endmodule

// ===== rtl/core/gtr_back.sv =====
`include "assert_macros.svh"

module gtr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [gtr_pkg::ADDR_W-1:0]    fb_base,
    input  logic [gtr_pkg::LP_W-1:0]      line_pixels,
    input  logic                          q_valid,
    input  gtr_pkg::q_item_t              q_item,
    output logic                          q_pop,
    output logic                          result_valid,
    output logic [gtr_pkg::ADDR_W-1:0]    write_address,
    output logic [gtr_pkg::BYTE_W-1:0]    pixel_mask,
    output logic                          last_row
);
    import gtr_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    localparam int FONT_DEPTH = 1 << FONT_AW;

    logic [BYTE_W-1:0]  font_mem [FONT_DEPTH];
    logic [BYTE_W-1:0]  rd_data_reg;

    logic               state_reg, state_next;
    logic [RCNT_W-1:0]  rcnt_reg, rcnt_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   crow_reg, crow_next;
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [Y_W-1:0]     y_reg, y_next;
    logic [FONT_AW-1:0] faddr_reg, faddr_next;

    logic               s1_valid_reg;
    logic               s1_last_reg;
    logic [PROD_W-1:0]  s1_prod_reg;

    logic               result_valid_reg;
    logic [ADDR_W-1:0]  write_address_reg;
    logic [BYTE_W-1:0]  pixel_mask_reg;
    logic               last_row_reg;

    logic               issue;
    logic               issue_last;
    logic               mem_we;
    logic [FONT_AW-1:0] raddr;
    logic [COL_W-1:0]   col_limit;
    logic               col_wrap;

    assign q_pop      = (state_reg == ST_IDLE) && q_valid;
    assign issue      = (state_reg == ST_RUN);
    assign issue_last = issue && (rcnt_reg == LAST_GLYPH_ROW);
    assign mem_we     = q_pop && (q_item.kind == KIND_LOAD);
    assign raddr      = faddr_reg + FONT_AW'(rcnt_reg);

    assign col_limit  = line_pixels[LP_W-1:3];
    assign col_wrap   = ({1'b0, col_reg} + 12'd1) >= {1'b0, col_limit};

    always_comb
    begin
        state_next = state_reg;
        rcnt_next  = rcnt_reg;
        col_next   = col_reg;
        crow_next  = crow_reg;
        base_next  = base_reg;
        y_next     = y_reg;
        faddr_next = faddr_reg;

        if (q_pop)
        begin
            unique case (q_item.kind)
                KIND_NEWLINE:
                begin
                    col_next  = '0;
                    crow_next = crow_reg + ROW_W'(1);
                end
                KIND_DRAW:
                begin
                    state_next = ST_RUN;
                    rcnt_next  = '0;
                    base_next  = fb_base + {32'd0, col_reg, 5'd0};
                    y_next     = {crow_reg, 4'd0};
                    faddr_next = q_item.font_addr;
                end
                default:
                begin
                    // font loads are written straight into the store
                end
            endcase
        end
        else if (issue)
        begin
            rcnt_next = rcnt_reg + RCNT_W'(1);
            y_next    = y_reg + Y_W'(1);
            if (issue_last)
            begin
                state_next = ST_IDLE;
                // cursor moves as the last row's font read is issued
                if (col_wrap)
                begin
                    col_next  = '0;
                    crow_next = crow_reg + ROW_W'(1);
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rcnt_reg         <= '0;
            col_reg          <= '0;
            crow_reg         <= '0;
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rcnt_reg         <= rcnt_next;
            col_reg          <= col_next;
            crow_reg         <= crow_next;
            s1_valid_reg     <= issue;
            result_valid_reg <= s1_valid_reg;
        end
    end

    // payload pipeline: font read and row product, then the address add
    always_ff @(posedge clk)
    begin
        base_reg          <= base_next;
        y_reg             <= y_next;
        faddr_reg         <= faddr_next;
        s1_last_reg       <= issue_last;
        s1_prod_reg       <= PROD_W'(y_reg) * PROD_W'(line_pixels);
        write_address_reg <= base_reg + {16'd0, s1_prod_reg, 2'd0};
        pixel_mask_reg    <= rd_data_reg;
        last_row_reg      <= s1_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            font_mem[q_item.font_addr] <= q_item.font_byte;
        end
        rd_data_reg <= font_mem[raddr];
    end

    assign result_valid  = result_valid_reg;
    assign write_address = write_address_reg;
    assign pixel_mask    = pixel_mask_reg;
    assign last_row      = last_row_reg && result_valid_reg;

    `GTR_ASSERT_NXT(a_stage_to_out, clk, rst_n, s1_valid_reg, result_valid_reg)
    `GTR_ASSERT_NXT(a_no_stray_beat, clk, rst_n, !s1_valid_reg, !result_valid_reg)
    `GTR_ASSERT_IMP(a_pop_only_idle, clk, rst_n, q_pop, state_reg == ST_IDLE && q_valid)
    `GTR_ASSERT_IMP(a_last_ends_run, clk, rst_n, s1_valid_reg && s1_last_reg, state_reg == ST_IDLE)

endmodule

// ===== rtl/core/glyph_text_renderer.sv =====
// channel   signals                                          direction  handshake
// item      start, cmd, char_code, font_index, font_byte     in         start && !busy
// result    result_valid, write_address, pixel_mask, last_row out       result_valid, one cycle
// config    psel, penable, pwrite, paddr, pwdata, prdata     in/out     apb, pready tied high
//
// a draw sets up the row base as it is popped, then reads one glyph row per cycle from the
// font store's read port; each row read passes the font read and output registers to a result.
// loads and newlines act when popped; a two-entry queue lets the front accept while a draw runs.
// rst_n clears cursor, queue and fb_base, sets line_pixels to 1024; the font store has no reset.
// results cannot be stalled: a beat is taken in its single strobe cycle.
module glyph_text_renderer #(
    parameter int GLYPH_COUNT = 256,
    parameter int GLYPH_BYTES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cmd,
    input  logic [gtr_pkg::BYTE_W-1:0]    char_code,
    input  logic [gtr_pkg::FONT_AW-1:0]   font_index,
    input  logic [gtr_pkg::BYTE_W-1:0]    font_byte,
    output logic                          result_valid,
    output logic [gtr_pkg::ADDR_W-1:0]    write_address,
    output logic [gtr_pkg::BYTE_W-1:0]    pixel_mask,
    output logic                          last_row,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gtr_pkg::PADDR_W-1:0]   paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready
);
    import gtr_pkg::*;

    logic [ADDR_W-1:0] fb_base_reg;
    logic [LP_W-1:0]   line_pixels_reg;
    logic              cfg_we;
    logic              reg_sel;

    logic              q_valid;
    logic              q_pop;
    q_item_t           q_item;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_base_reg     <= '0;
            line_pixels_reg <= LINE_PIXELS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_sel)
                REG_FB_BASE:     fb_base_reg     <= pwdata[ADDR_W-1:0];
                REG_LINE_PIXELS: line_pixels_reg <= pwdata[LP_W-1:0];
                default:         fb_base_reg     <= fb_base_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_FB_BASE:     prdata = {16'd0, fb_base_reg};
            REG_LINE_PIXELS: prdata = {50'd0, line_pixels_reg};
            default:         prdata = '0;
        endcase
    end

    gtr_front #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .GLYPH_BYTES (GLYPH_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .char_code  (char_code),
        .font_index (font_index),
        .font_byte  (font_byte),
        .busy       (busy),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    gtr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .fb_base       (fb_base_reg),
        .line_pixels   (line_pixels_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .result_valid  (result_valid),
        .write_address (write_address),
        .pixel_mask    (pixel_mask),
        .last_row      (last_row)
    );

endmodule

// ===== tb/glyph_text_renderer_checker.sv =====
`timescale 1ns / 100ps

module glyph_text_renderer_checker #(
    parameter int GLYPH_COUNT = 256,
    parameter int GLYPH_BYTES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          cmd,
    input  logic [gtr_pkg::BYTE_W-1:0]    char_code,
    input  logic [gtr_pkg::FONT_AW-1:0]   font_index,
    input  logic [gtr_pkg::BYTE_W-1:0]    font_byte,
    input  logic                          result_valid,
    input  logic [gtr_pkg::ADDR_W-1:0]    write_address,
    input  logic [gtr_pkg::BYTE_W-1:0]    pixel_mask,
    input  logic                          last_row,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gtr_pkg::PADDR_W-1:0]   paddr,
    input  logic [63:0]                   pwdata,
    input  logic                          pready,
    output int                            fail_count,
    output int                            pending
);

    import gtr_pkg::*;

    // paddr bit that picks the register in 8-byte slots
    localparam int REG_SEL_BIT = 3;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] mask;
        logic              last;
    } glyph_row_t;

    logic [BYTE_W-1:0] font_copy [0:(1<<FONT_AW)-1];
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [ADDR_W-1:0] base_addr;
    logic [LP_W-1:0]   line_px;
    glyph_row_t        due_rows [$];
    int                mismatches;

    assign fail_count = mismatches;

    always @(posedge clk or negedge rst_n)
    begin
        glyph_row_t         want;
        logic [63:0]        addr;
        logic [Y_W-1:0]     y_pix;
        logic [FONT_AW-1:0] pos;
        int                 glyph;
        if (!rst_n)
        begin
            cur_col    = '0;
            cur_row    = '0;
            base_addr  = '0;
            line_px    = LINE_PIXELS_RESET;
            mismatches = 0;
            due_rows.delete();
            pending <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (due_rows.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected glyph row beat: address %h mask %h last %b",
                                 write_address, pixel_mask, last_row);
                end
                else
                begin
                    want = due_rows.pop_front();
                    if (write_address !== want.addr || pixel_mask !== want.mask ||
                        last_row !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"glyph row mismatch: expected address %h mask %h last %b,",
                                      " got address %h mask %h last %b"},
                                     want.addr, want.mask, want.last,
                                     write_address, pixel_mask, last_row);
                    end
                end
            end

            if (start && !busy)
            begin
                if (cmd == CMD_LOAD)
                    font_copy[font_index] = font_byte;
                else if (char_code == NEWLINE_CODE)
                begin
                    cur_col = '0;
                    cur_row = cur_row + ROW_W'(1);
                end
                else
                begin
                    glyph = int'(char_code) % GLYPH_COUNT;
                    for (int r = 0; r <= int'(LAST_GLYPH_ROW); r++)
                    begin
                        pos   = FONT_AW'(glyph * GLYPH_BYTES + r);
                        y_pix = {cur_row, RCNT_W'(r)};
                        addr  = 64'(base_addr) + 64'(cur_col) * 64'd32 +
                                64'(y_pix) * 64'(line_px) * 64'd4;
                        want.addr = addr[ADDR_W-1:0];
                        want.mask = font_copy[pos];
                        want.last = (r == int'(LAST_GLYPH_ROW));
                        due_rows.push_back(want);
                    end
                    // wrap once the next column would fall off the line
                    if (int'(cur_col) + 1 >= int'(line_px) / 8)
                    begin
                        cur_col = '0;
                        cur_row = cur_row + ROW_W'(1);
                    end
                    else
                        cur_col = cur_col + COL_W'(1);
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                if (paddr[REG_SEL_BIT] == REG_LINE_PIXELS)
                    line_px = pwdata[LP_W-1:0];
                else
                    base_addr = pwdata[ADDR_W-1:0];
            end

            pending <= due_rows.size();
        end
    end

endmodule

// ===== tb/glyph_text_renderer_tb.sv =====
`timescale 1ns / 100ps

module glyph_text_renderer_tb;

    import gtr_pkg::*;

    localparam logic CMD_DRAW = ~CMD_LOAD;
    localparam logic [PADDR_W-1:0] ADDR_FB_BASE     = {REG_FB_BASE, 3'b000};
    localparam logic [PADDR_W-1:0] ADDR_LINE_PIXELS = {REG_LINE_PIXELS, 3'b000};
    localparam int SETTLE_CYCLES = 48;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RUN_LIMIT_NS  = 2000000;
    localparam int MIX_ITEMS     = 75;
    localparam int SWEEP_ITEMS   = 30;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                cmd;
    logic [BYTE_W-1:0]   char_code;
    logic [FONT_AW-1:0]  font_index;
    logic [BYTE_W-1:0]   font_byte;
    logic                result_valid;
    logic [ADDR_W-1:0]   write_address;
    logic [BYTE_W-1:0]   pixel_mask;
    logic                last_row;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [63:0]         pwdata;
    logic [63:0]         prdata;
    logic                pready;
    int                  fail_count;
    int                  pending;

    bit                  idle_on;
    bit                  stalled;
    bit                  first_glyph;
    logic [4095:0]       row_written;
    bit [255:0]          glyph_ready;

    glyph_text_renderer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .char_code     (char_code),
        .font_index    (font_index),
        .font_byte     (font_byte),
        .result_valid  (result_valid),
        .write_address (write_address),
        .pixel_mask    (pixel_mask),
        .last_row      (last_row),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    glyph_text_renderer_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .char_code     (char_code),
        .font_index    (font_index),
        .font_byte     (font_byte),
        .result_valid  (result_valid),
        .write_address (write_address),
        .pixel_mask    (pixel_mask),
        .last_row      (last_row),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("glyph_text_renderer_tb failed");
        $finish;
    end

    // one item beat; returns at the edge that accepts it
    task automatic send_item(input logic c, input logic [BYTE_W-1:0] code,
                             input logic [FONT_AW-1:0] idx, input logic [BYTE_W-1:0] fbyte);
        if (idle_on && $urandom_range(0, 99) < 6)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start      <= 1'b1;
        cmd        <= c;
        char_code  <= code;
        font_index <= idx;
        font_byte  <= fbyte;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (c == CMD_LOAD)
        begin
            row_written[idx] = 1'b1;
            glyph_ready[idx[11:4]] = &row_written[{idx[11:4], 4'b0000} +: 16];
        end
    endtask

    task automatic send_load(input logic [FONT_AW-1:0] idx, input logic [BYTE_W-1:0] fbyte);
        send_item(CMD_LOAD, BYTE_W'($urandom), idx, fbyte);
    endtask

    task automatic send_draw(input logic [BYTE_W-1:0] code);
        send_item(CMD_DRAW, code, FONT_AW'($urandom), BYTE_W'($urandom));
    endtask

    // only glyphs whose sixteen rows are all in the font store, never the newline code
    function automatic logic [BYTE_W-1:0] pick_ready_glyph();
        logic [BYTE_W-1:0] g;
        g = BYTE_W'($urandom);
        while (!glyph_ready[g] || g == NEWLINE_CODE)
            g = BYTE_W'($urandom);
        return g;
    endfunction

    task automatic drain_rows();
        int waited;
        waited = 0;
        start <= 1'b0;
        @(posedge clk);
        while ((pending != 0 || busy) && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (waited >= DRAIN_LIMIT)
            stalled = 1'b1;
        // queued loads and newlines give no beat, let them settle
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] a, input logic [63:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_screen(input logic [ADDR_W-1:0] base, input logic [LP_W-1:0] lp);
        write_reg(ADDR_FB_BASE, 64'(base));
        write_reg(ADDR_LINE_PIXELS, 64'(lp));
    endtask

    task automatic run_mix(input int n_items);
        int                sent;
        int                choice;
        int                rows;
        logic [BYTE_W-1:0] g;
        sent = 0;
        while (sent < n_items)
        begin
            choice = $urandom_range(0, 99);
            if (choice < 14)
            begin
                g = first_glyph ? '0 : BYTE_W'($urandom);
                first_glyph = 1'b0;
                // now and then a glyph is left partly loaded
                rows = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 15) : 16;
                for (int r = 0; r < rows; r++)
                    send_load({g, 4'(r)},
                              ($urandom_range(0, 9) == 0) ? 8'h00 : BYTE_W'($urandom));
                sent += rows;
            end
            else if (choice < 24)
            begin
                send_load(FONT_AW'($urandom), BYTE_W'($urandom));
                sent++;
            end
            else if (choice < 32)
            begin
                send_draw(NEWLINE_CODE);
                sent++;
            end
            else
            begin
                send_draw(pick_ready_glyph());
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = CMD_LOAD;
        char_code   = '0;
        font_index  = '0;
        font_byte   = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        idle_on     = 1'b1;
        stalled     = 1'b0;
        first_glyph = 1'b1;
        row_written = '0;
        glyph_ready = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // glyph 255 with an empty row, a full row and each edge pixel
        for (int r = 0; r < 16; r++)
            send_load({8'hFF, 4'(r)},
                      (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : (r == 2) ? 8'h80 :
                      (r == 3) ? 8'h01 : BYTE_W'($urandom));
        send_draw(8'hFF);
        send_draw(NEWLINE_CODE);
        send_draw(8'hFF);
        send_draw(8'hFF);
        drain_rows();

        // one column per line, so every draw wraps; base near the top of the address space
        set_screen(48'hFFFF_FFFF_FF00, 14'd8);
        send_draw(8'hFF);
        send_draw(8'hFF);
        send_draw(NEWLINE_CODE);
        drain_rows();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_screen(ADDR_W'({$urandom, $urandom}), LP_W'($urandom_range(8, 128)));
                1: set_screen('0, 14'd8192);
                2: set_screen({16'hFFFF, 32'($urandom)}, LP_W'($urandom_range(8, 64)));
                default: set_screen(ADDR_W'({$urandom, $urandom}), 14'd8);
            endcase
            idle_on = (phase != 1);
            run_mix(MIX_ITEMS);
            drain_rows();
        end

        // a run of newlines with a draw now and then
        idle_on = 1'b1;
        set_screen(ADDR_W'({$urandom, $urandom}), 14'd8192);
        for (int i = 0; i < SWEEP_ITEMS; i++)
        begin
            if (i % 10 == 9)
                send_draw(pick_ready_glyph());
            else
                send_draw(NEWLINE_CODE);
        end
        send_draw(pick_ready_glyph());
        drain_rows();

        if (fail_count == 0 && pending == 0 && !stalled)
            $display("glyph_text_renderer_tb passed");
        else
            $display("glyph_text_renderer_tb failed");
        $finish;
    end

endmodule
